>>> design/mono_glyph_pixel_expander_core_macros.svh
// Assertion macros shared by the glyph expander modules.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef MONO_GLYPH_PIXEL_EXPANDER_CORE_MACROS_SVH
`define MONO_GLYPH_PIXEL_EXPANDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MGPE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mgpe: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MGPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mgpe: next-cycle check failed");

`endif

>>> design/mgpe_pkg.sv
// Shared types, constants and helper functions of the glyph pixel expander.
// Used by the channel interfaces and every module of the block.
package mgpe_pkg;

  // Defaults of the top-level parameters
  localparam int COORD_BITS_DEFAULT    = 12;
  localparam int MAX_GLYPH_DIM_DEFAULT = 64;

  // Field widths
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 24;
  localparam int BITMAP_W    = 8;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 2;
  localparam int DIM_W       = 7;
  localparam int RES_W       = 13;
  localparam int FMT_W       = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;
  localparam int PIX_IDX_W   = 3;
  localparam int BYTE_COL_W  = 4;
  localparam int ROW_OFS_W   = 7;
  localparam int BPP_W       = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_RESOLUTION   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_RESOLUTION   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DRAW_TO_HIDDEN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VISIBLE_BASE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HIDDEN_BASE    = 3'd7;

  // Pixel formats
  localparam logic [FMT_W-1:0] FMT_8BPP  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_16BPP = 2'd1;
  localparam logic [FMT_W-1:0] FMT_24BPP = 2'd2;
  localparam logic [FMT_W-1:0] FMT_32BPP = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0]  GLYPH_WIDTH_RST  = 7'd8;
  localparam logic [DIM_W-1:0]  GLYPH_HEIGHT_RST = 7'd16;
  localparam logic [RES_W-1:0]  X_RES_RST        = 13'd640;
  localparam logic [RES_W-1:0]  Y_RES_RST        = 13'd480;

  // One classified bitmap byte, as queued between front and back
  typedef struct packed {
    logic [BITMAP_W-1:0] enable_mask;  // bit k: pixel k is written
    logic [ADDR_W-1:0]   linear;       // x + y * x_resolution of pixel 0
    logic [ADDR_W-1:0]   base;
    logic [COLOR_W-1:0]  data;
    logic [COUNT_W-1:0]  count;
    logic [FMT_W-1:0]    fmt;
  } mgpe_entry_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } mgpe_q_status_t;

  function automatic logic [BPP_W-1:0] bpp_bytes(input logic [FMT_W-1:0] fmt);
    logic [BPP_W-1:0] b;
    unique case (fmt)
      FMT_8BPP:  b = 3'd1;
      FMT_16BPP: b = 3'd2;
      FMT_24BPP: b = 3'd3;
      FMT_32BPP: b = 3'd4;
      default:   b = 3'd4;
    endcase
    return b;
  endfunction

  // Multiply by bytes per pixel with shifts and one add
  function automatic logic [ADDR_W-1:0] scale_bpp(input logic [FMT_W-1:0] fmt,
                                                  input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] s;
    unique case (fmt)
      FMT_8BPP:  s = v;
      FMT_16BPP: s = v << 1;
      FMT_24BPP: s = v + (v << 1);
      FMT_32BPP: s = v << 2;
      default:   s = v << 2;
    endcase
    return s;
  endfunction

endpackage

>>> design/mgpe_if.sv
// Valid/ready channel interfaces: glyph bytes in, pixel writes out.
// Depends on mgpe_pkg for field widths.
interface mgpe_glyph_if import mgpe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                first_of_glyph;
  logic [COORD_W-1:0]  glyph_x;
  logic [COORD_W-1:0]  glyph_y;
  logic [COLOR_W-1:0]  pixel_color;
  logic [BITMAP_W-1:0] bitmap_byte;

  modport source (output valid, first_of_glyph, glyph_x, glyph_y, pixel_color,
                  bitmap_byte, input ready);
  modport sink (input valid, first_of_glyph, glyph_x, glyph_y, pixel_color,
                bitmap_byte, output ready);
endinterface

interface mgpe_pixel_if import mgpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ADDR_W-1:0]  byte_address;
  logic [COLOR_W-1:0] write_data;
  logic [COUNT_W-1:0] byte_count;
  logic               last_of_byte;

  modport source (output valid, write_enable, byte_address, write_data, byte_count,
                  last_of_byte, input ready);
  modport sink (input valid, write_enable, byte_address, write_data, byte_count,
                last_of_byte, output ready);
endinterface

>>> design/mgpe_front.sv
// Front end: configuration registers, glyph origin/counter state, and
// per-byte classification into queue entries. Depends on mgpe_pkg, mgpe_if.
module mgpe_front import mgpe_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEFAULT,
  parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mgpe_glyph_if.sink            glyph,
  input  mgpe_q_status_t        q_status,
  output logic                  push,
  output mgpe_entry_t           entry
);

  localparam int XW   = COORD_BITS + 1;   // origin plus up to 127 pixels
  localparam int PW   = XW + RES_W;
  localparam int CLMW = 9;                // holds MAX_GLYPH_DIM up to 256

  // Configuration registers
  logic [DIM_W-1:0]  glyph_width;
  logic [DIM_W-1:0]  glyph_height;
  logic [RES_W-1:0]  x_resolution;
  logic [RES_W-1:0]  y_resolution;
  logic [FMT_W-1:0]  pixel_format;
  logic              draw_to_hidden;
  logic [ADDR_W-1:0] visible_base;
  logic [ADDR_W-1:0] hidden_base;

  // Glyph state
  logic [COORD_BITS-1:0] origin_column;
  logic [COORD_BITS-1:0] origin_row;
  logic [COLOR_W-1:0]    latched_color;
  logic [BYTE_COL_W-1:0] byte_column;
  logic [ROW_OFS_W-1:0]  row_offset;

  logic [COORD_BITS-1:0] cur_col;
  logic [COORD_BITS-1:0] cur_row;
  logic [COLOR_W-1:0]    cur_color;
  logic [BYTE_COL_W-1:0] cur_bc;
  logic [ROW_OFS_W-1:0]  cur_ro;
  logic [XW-1:0]         y;
  logic [XW-1:0]         x0;
  logic [PW-1:0]         row_product;
  logic                  row_in;
  logic                  bases_ok;
  logic [BITMAP_W-1:0]   mask;
  logic [CLMW-1:0]       width_clamped;
  logic [CLMW-1:0]       height_clamped;
  logic [CLMW-1:0]       width_bytes;
  logic [BYTE_COL_W-1:0] byte_column_next;
  logic [ROW_OFS_W-1:0]  row_offset_next;
  logic [ROW_OFS_W-1:0]  row_inc;

  assign glyph.ready = q_status.not_full;
  assign push        = glyph.valid && q_status.not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width    <= GLYPH_WIDTH_RST;
      glyph_height   <= GLYPH_HEIGHT_RST;
      x_resolution   <= X_RES_RST;
      y_resolution   <= Y_RES_RST;
      pixel_format   <= FMT_32BPP;
      draw_to_hidden <= 1'b0;
      visible_base   <= '0;
      hidden_base    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:    glyph_width    <= cfg_data[DIM_W-1:0];
        REG_GLYPH_HEIGHT:   glyph_height   <= cfg_data[DIM_W-1:0];
        REG_X_RESOLUTION:   x_resolution   <= cfg_data[RES_W-1:0];
        REG_Y_RESOLUTION:   y_resolution   <= cfg_data[RES_W-1:0];
        REG_PIXEL_FORMAT:   pixel_format   <= cfg_data[FMT_W-1:0];
        REG_DRAW_TO_HIDDEN: draw_to_hidden <= cfg_data[0];
        REG_VISIBLE_BASE:   visible_base   <= cfg_data[ADDR_W-1:0];
        REG_HIDDEN_BASE:    hidden_base    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // A first byte restarts the glyph before it is drawn
  always_comb begin
    if (glyph.first_of_glyph) begin
      cur_col   = COORD_BITS'(glyph.glyph_x);
      cur_row   = COORD_BITS'(glyph.glyph_y);
      cur_color = glyph.pixel_color;
      cur_bc    = '0;
      cur_ro    = '0;
    end else begin
      cur_col   = origin_column;
      cur_row   = origin_row;
      cur_color = latched_color;
      cur_bc    = byte_column;
      cur_ro    = row_offset;
    end
  end

  assign y           = XW'(cur_row) + XW'(cur_ro);
  assign x0          = XW'(cur_col) + XW'({cur_bc, 3'b000});
  assign row_product = PW'(y) * PW'(x_resolution);
  assign row_in      = 32'(y) < 32'(y_resolution);
  assign bases_ok    = (visible_base != '0) && (hidden_base != '0);

  always_comb begin
    for (int k = 0; k < BITMAP_W; k++) begin
      mask[k] = glyph.bitmap_byte[BITMAP_W-1-k] && row_in && bases_ok &&
                (32'(x0 + XW'(k)) < 32'(x_resolution));
    end
  end

  always_comb begin
    entry.enable_mask = mask;
    entry.linear      = ADDR_W'(x0) + ADDR_W'(row_product);
    entry.base        = draw_to_hidden ? hidden_base : visible_base;
    entry.fmt         = pixel_format;
    unique case (pixel_format)
      FMT_8BPP: begin
        entry.data  = {16'h0000, cur_color[7:0]};
        entry.count = 2'd1;
      end
      FMT_16BPP: begin
        entry.data  = {8'h00, cur_color[15:0]};
        entry.count = 2'd2;
      end
      default: begin
        entry.data  = cur_color;
        entry.count = 2'd3;
      end
    endcase
  end

  // Row and column stepping with clamped glyph size
  always_comb begin
    if (glyph_width == '0) begin
      width_clamped = CLMW'(1);
    end else if (CLMW'(glyph_width) > CLMW'(MAX_GLYPH_DIM)) begin
      width_clamped = CLMW'(MAX_GLYPH_DIM);
    end else begin
      width_clamped = CLMW'(glyph_width);
    end
    if (glyph_height == '0) begin
      height_clamped = CLMW'(1);
    end else if (CLMW'(glyph_height) > CLMW'(MAX_GLYPH_DIM)) begin
      height_clamped = CLMW'(MAX_GLYPH_DIM);
    end else begin
      height_clamped = CLMW'(glyph_height);
    end
    width_bytes      = (width_clamped + CLMW'(7)) >> 3;
    byte_column_next = cur_bc + 1'b1;
    row_offset_next  = cur_ro;
    row_inc          = cur_ro + 1'b1;
    if (CLMW'(byte_column_next) >= width_bytes || byte_column_next == '0) begin
      byte_column_next = '0;
      row_offset_next  = (CLMW'(row_inc) >= height_clamped) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_column <= '0;
      origin_row    <= '0;
      latched_color <= '0;
      byte_column   <= '0;
      row_offset    <= '0;
    end else if (push) begin
      origin_column <= cur_col;
      origin_row    <= cur_row;
      latched_color <= cur_color;
      byte_column   <= byte_column_next;
      row_offset    <= row_offset_next;
    end
  end

endmodule

>>> design/mgpe_queue.sv
// Short FIFO of classified bytes between front and back end.
// Depends on mgpe_pkg and the shared assertion macros.
`include "mono_glyph_pixel_expander_core_macros.svh"
module mgpe_queue import mgpe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mgpe_entry_t    push_entry,
  input  logic           pop,
  output mgpe_entry_t    head,
  output mgpe_q_status_t status
);

  mgpe_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.not_empty = (count != '0);
  assign status.not_full  = (count != QCNT_W'(QUEUE_DEPTH));
  assign head             = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MGPE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `MGPE_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, count != '0)
  `MGPE_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == QCNT_W'($past(count) + 1'b1))

endmodule

>>> design/mgpe_back.sv
// Back end: expands one queued byte into eight pixel writes, one per cycle while the
// pixel sink is ready, through a registered output stage. Depends on mgpe_pkg, mgpe_if, macros.
`include "mono_glyph_pixel_expander_core_macros.svh"
module mgpe_back import mgpe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  mgpe_entry_t    head,
  input  mgpe_q_status_t q_status,
  output logic           pop,
  mgpe_pixel_if.source   pixel
);

  logic                 work_valid;
  logic [ADDR_W-1:0]    work_addr;
  logic [PIX_IDX_W-1:0] work_k;
  logic [BITMAP_W-1:0]  work_mask;
  logic [COLOR_W-1:0]   work_data;
  logic [COUNT_W-1:0]   work_count;
  logic [FMT_W-1:0]     work_fmt;

  logic issue;
  logic last_pixel;
  logic load;

  assign issue      = work_valid && (!pixel.valid || pixel.ready);
  assign last_pixel = (work_k == PIX_IDX_W'(BITMAP_W - 1));
  assign load       = q_status.not_empty && (!work_valid || (issue && last_pixel));
  assign pop        = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_k     <= '0;
    end else if (load) begin
      work_valid <= 1'b1;
      work_k     <= '0;
    end else if (issue && last_pixel) begin
      work_valid <= 1'b0;
    end else if (issue) begin
      work_k <= work_k + 1'b1;
    end
  end

  // Address of pixel 0 on load, then step by bytes per pixel
  always_ff @(posedge clk) begin
    if (load) begin
      work_addr  <= head.base + scale_bpp(head.fmt, head.linear);
      work_mask  <= head.enable_mask;
      work_data  <= head.data;
      work_count <= head.count;
      work_fmt   <= head.fmt;
    end else if (issue) begin
      work_addr <= work_addr + ADDR_W'(bpp_bytes(work_fmt));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (issue) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pixel.write_enable <= work_mask[work_k];
      pixel.byte_address <= work_addr;
      pixel.write_data   <= work_data;
      pixel.byte_count   <= work_count;
      pixel.last_of_byte <= last_pixel;
    end
  end

  `MGPE_ASSERT_NEXT(a_hold_when_stalled, clk, rst, work_valid && !issue, $stable(work_k) && $stable(work_addr))
  `MGPE_ASSERT_NEXT(a_load_starts, clk, rst, load, work_valid && work_k == '0)
  `MGPE_ASSERT_NEXT(a_drain_idle, clk, rst, issue && last_pixel && !load, !work_valid)

endmodule

>>> design/mono_glyph_pixel_expander_core.sv
// Glyph color expansion: one bitmap byte in, eight pixel writes out, pixel 0 first.
// Each byte passes through the queue and work registers to the registered output.
// Throughput: one pixel write per cycle while the pixel sink is ready; the single
// output port sets this, and a 2-entry queue lets input run ahead of output.
// Reset (rst, synchronous, active high) restores register defaults and clears
// glyph state, queue and output; no clearing pass is needed.
module mono_glyph_pixel_expander_core import mgpe_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEFAULT,
  parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mgpe_glyph_if.sink            glyph,
  mgpe_pixel_if.source          pixel
);

  logic           push;
  logic           pop;
  mgpe_entry_t    push_entry;
  mgpe_entry_t    head;
  mgpe_q_status_t q_status;

  mgpe_front #(
    .COORD_BITS    (COORD_BITS),
    .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .glyph     (glyph),
    .q_status  (q_status),
    .push      (push),
    .entry     (push_entry)
  );

  mgpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  mgpe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .pixel    (pixel)
  );

endmodule
